// File: hdl/bchd_pkg.sv
// Shared types, codes and reset values for the button click and hold detector.
package bchd_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CodeW  = 3;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [TimeW-1:0]   time_ms_t;
  typedef logic [CfgW-1:0]    cfg_ms_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  typedef enum logic [CodeW-1:0] {
    EV_NONE   = 3'd0,
    EV_CLICK  = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_HOLD   = 3'd3,
    EV_LONG   = 3'd4
  } event_e;

  localparam cfg_idx_t CFG_DEBOUNCE   = 2'd0;
  localparam cfg_idx_t CFG_DOUBLE_GAP = 2'd1;
  localparam cfg_idx_t CFG_HOLD       = 2'd2;
  localparam cfg_idx_t CFG_LONG_HOLD  = 2'd3;

  localparam cfg_ms_t DEBOUNCE_RST   = 16'd20;
  localparam cfg_ms_t DOUBLE_GAP_RST = 16'd250;
  localparam cfg_ms_t HOLD_RST       = 16'd1000;
  localparam cfg_ms_t LONG_HOLD_RST  = 16'd3000;

  localparam time_ms_t STAMP_RST = '1;

endpackage

// File: hdl/button_click_hold_detector.sv
// Button click, double click, hold and long hold detector, top level.
// A sample passes the input register, then the result register, before its event shows
// on the outputs; it is held there longer only while out_ready_i is low. Throughput: one
// sample per cycle while out_ready_i does not stall the result; the state update is
// a single pass of subtract/compare logic between the input and result registers.
// Reset clears the pipeline and loads the register and timestamp reset values.
module button_click_hold_detector (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    pressed_level_i,
  input  logic [31:0]             now_ms_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [2:0]              event_code_o,
  input  logic                    cfg_we_i,
  input  bchd_pkg::cfg_idx_t      cfg_idx_i,
  input  bchd_pkg::cfg_ms_t       cfg_wdata_i
);

  // configuration
  bchd_pkg::cfg_ms_t debounce_q, double_gap_q, hold_q, long_hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= bchd_pkg::DEBOUNCE_RST;
      double_gap_q <= bchd_pkg::DOUBLE_GAP_RST;
      hold_q       <= bchd_pkg::HOLD_RST;
      long_hold_q  <= bchd_pkg::LONG_HOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bchd_pkg::CFG_DEBOUNCE:   debounce_q   <= cfg_wdata_i;
        bchd_pkg::CFG_DOUBLE_GAP: double_gap_q <= cfg_wdata_i;
        bchd_pkg::CFG_HOLD:       hold_q       <= cfg_wdata_i;
        bchd_pkg::CFG_LONG_HOLD:  long_hold_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  logic               s1_valid_q;
  logic               s1_level_q;
  bchd_pkg::time_ms_t s1_now_q;
  logic               advance;
  logic               out_valid_q;
  bchd_pkg::event_e   code_q, code_d;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_level_q <= pressed_level_i;
      s1_now_q   <= now_ms_i;
    end
  end

  // detector state
  logic               last_level_q, last_level_d;
  bchd_pkg::time_ms_t press_time_q, press_time_d;
  bchd_pkg::time_ms_t release_time_q, release_time_d;
  logic dbl_wait_q, dbl_wait_d;
  logic dbl_on_rel_q, dbl_on_rel_d;
  logic single_ok_q, single_ok_d;
  logic skip_rel_q, skip_rel_d;
  logic hold_done_q, hold_done_d;
  logic long_done_q, long_done_d;

  bchd_pkg::time_ms_t since_rel, since_press;
  logic               press_edge, release_edge;

  always_comb begin
    since_rel   = s1_now_q - release_time_q;
    since_press = s1_now_q - press_time_q;

    last_level_d   = s1_level_q;
    press_time_d   = press_time_q;
    release_time_d = release_time_q;
    dbl_wait_d     = dbl_wait_q;
    dbl_on_rel_d   = dbl_on_rel_q;
    single_ok_d    = single_ok_q;
    skip_rel_d     = skip_rel_q;
    hold_done_d    = hold_done_q;
    long_done_d    = long_done_q;
    code_d         = bchd_pkg::EV_NONE;

    press_edge   = s1_level_q && !last_level_q &&
                   (since_rel > {16'd0, debounce_q});
    release_edge = !s1_level_q && last_level_q &&
                   (since_press > {16'd0, debounce_q});

    if (press_edge) begin
      press_time_d = s1_now_q;
      since_press  = '0;
      skip_rel_d   = 1'b0;
      single_ok_d  = 1'b1;
      hold_done_d  = 1'b0;
      long_done_d  = 1'b0;
      dbl_on_rel_d = (since_rel < {16'd0, double_gap_q}) && !dbl_on_rel_q && dbl_wait_q;
      dbl_wait_d   = 1'b0;
    end else if (release_edge && !skip_rel_q) begin
      release_time_d = s1_now_q;
      since_rel      = '0;
      if (!dbl_on_rel_q) begin
        dbl_wait_d = 1'b1;
      end else begin
        code_d       = bchd_pkg::EV_DOUBLE;
        dbl_on_rel_d = 1'b0;
        dbl_wait_d   = 1'b0;
        single_ok_d  = 1'b0;
      end
    end

    // single click once the double-click window has closed
    if (!s1_level_q && (since_rel >= {16'd0, double_gap_q}) && dbl_wait_d &&
        !dbl_on_rel_d && single_ok_d && (code_d != bchd_pkg::EV_DOUBLE)) begin
      code_d     = bchd_pkg::EV_CLICK;
      dbl_wait_d = 1'b0;
    end

    if (s1_level_q && (since_press >= {16'd0, hold_q})) begin
      if (!hold_done_d) begin
        code_d       = bchd_pkg::EV_HOLD;
        skip_rel_d   = 1'b1;
        dbl_on_rel_d = 1'b0;
        dbl_wait_d   = 1'b0;
        hold_done_d  = 1'b1;
      end
      if ((since_press >= {16'd0, long_hold_q}) && !long_done_d) begin
        code_d      = bchd_pkg::EV_LONG;
        long_done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q   <= 1'b1;
      press_time_q   <= bchd_pkg::STAMP_RST;
      release_time_q <= bchd_pkg::STAMP_RST;
      dbl_wait_q     <= 1'b0;
      dbl_on_rel_q   <= 1'b0;
      single_ok_q    <= 1'b1;
      skip_rel_q     <= 1'b0;
      hold_done_q    <= 1'b0;
      long_done_q    <= 1'b0;
    end else if (advance) begin
      last_level_q   <= last_level_d;
      press_time_q   <= press_time_d;
      release_time_q <= release_time_d;
      dbl_wait_q     <= dbl_wait_d;
      dbl_on_rel_q   <= dbl_on_rel_d;
      single_ok_q    <= single_ok_d;
      skip_rel_q     <= skip_rel_d;
      hold_done_q    <= hold_done_d;
      long_done_q    <= long_done_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      code_q <= code_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_code_o = code_q;

endmodule

// File: hdl/bchd_checker.sv
// Port-level checks for the button click and hold detector, bound to the top level.
module bchd_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [2:0]       event_code_o
);

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (event_code_o <= bchd_pkg::EV_LONG))
    else $error("event code out of range");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_code_o))
    else $error("stalled result dropped or changed");

  a_result_from_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without an input transfer two cycles earlier");

endmodule

bind button_click_hold_detector bchd_checker u_bchd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .event_code_o (event_code_o)
);
